/* design/assert_macros.svh */
// Assertion macros used by the top-level design file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent in a cycle implies consequent in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition never holds.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

/* design/vln_pkg.sv */
// Shared types and constants for the vector L2 normalisation unit.
// No dependencies.
package vln_pkg;

    localparam int TDATA_BITS  = 16;  // element and component field width
    localparam int COMP_BITS   = 16;
    localparam int ROOT_BITS   = 15;  // magnitude bits resolved by the root unit
    localparam int SCALE_SHIFT = 28;  // Q1.14 squared
    localparam int BIT_CNT_W   = 4;

    typedef struct packed {
        logic store_we;   // write accepted element, square it for the sum
        logic rd_en;      // read stored element
        logic init;       // load root unit from read element
        logic step;       // one root unit iteration
        logic out_load;   // capture result into output register
        logic out_last;   // result is the last of the vector
        logic clear_sum;  // vector done
    } cmd_t;

endpackage

/* design/vln_ctrl.sv */
// Controller for the vector L2 normalisation unit: load, read, root iteration, output.
// Depends on vln_pkg.
module vln_ctrl #(
    parameter int MAX_LEN = 64,
    parameter int AW      = 6,
    parameter int CW      = 7
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tlast,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output vln_pkg::cmd_t        cmd,
    output logic [AW-1:0]        store_addr,
    output logic [AW-1:0]        rd_addr
);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SETTLE,
        ST_READ,
        ST_INIT,
        ST_ITER,
        ST_DONE
    } state_t;

    state_t                          state_reg, state_next;
    logic [CW-1:0]                   count_reg, count_next;
    logic [CW-1:0]                   idx_reg, idx_next;
    logic [vln_pkg::BIT_CNT_W-1:0]   bit_reg, bit_next;
    logic                            m_tvalid_reg, m_tvalid_next;
    logic                            accept;
    logic                            idx_last;

    assign s_tready   = (state_reg == ST_LOAD);
    assign accept     = s_tvalid && s_tready;
    assign idx_last   = (idx_reg == count_reg - CW'(1));
    assign m_tvalid   = m_tvalid_reg;
    assign store_addr = count_reg[AW-1:0];
    assign rd_addr    = idx_reg[AW-1:0];

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        bit_next      = bit_reg;
        cmd           = '0;
        case (state_reg)
            ST_LOAD: begin
                if (accept) begin
                    if (count_reg < CW'(MAX_LEN)) begin
                        cmd.store_we = 1'b1;
                        count_next   = count_reg + CW'(1);
                    end
                    if (s_tlast) begin
                        state_next = ST_SETTLE;
                    end
                end
            end
            ST_SETTLE: begin
                state_next = ST_READ;
            end
            ST_READ: begin
                cmd.rd_en  = 1'b1;
                state_next = ST_INIT;
            end
            ST_INIT: begin
                cmd.init   = 1'b1;
                bit_next   = '0;
                state_next = ST_ITER;
            end
            ST_ITER: begin
                cmd.step = 1'b1;
                bit_next = bit_reg + vln_pkg::BIT_CNT_W'(1);
                if (bit_reg == vln_pkg::BIT_CNT_W'(vln_pkg::ROOT_BITS - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = idx_last;
                    if (idx_last) begin
                        cmd.clear_sum = 1'b1;
                        count_next    = '0;
                        idx_next      = '0;
                        state_next    = ST_LOAD;
                    end else begin
                        idx_next   = idx_reg + CW'(1);
                        state_next = ST_READ;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase

        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            count_reg    <= '0;
            idx_reg      <= '0;
            bit_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            idx_reg      <= idx_next;
            bit_reg      <= bit_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

/* design/vln_datapath.sv */
// Datapath for the vector L2 normalisation unit: element store, sum of squares,
// shift-and-subtract root unit and output register. Depends on vln_pkg.
module vln_datapath #(
    parameter int MAX_LEN   = 64,
    parameter int ELEM_BITS = 16,
    parameter int AW        = 6
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  vln_pkg::cmd_t                    cmd,
    input  logic [vln_pkg::TDATA_BITS-1:0]   s_tdata,
    input  logic [AW-1:0]                    store_addr,
    input  logic [AW-1:0]                    rd_addr,
    output logic [vln_pkg::TDATA_BITS-1:0]   m_tdata,
    output logic                             m_tlast,
    output logic [0:0]                       m_tuser
);

    localparam int PW = 2 * ELEM_BITS;
    localparam int SW = 2 * ELEM_BITS + 7;
    localparam int W  = 2 * ELEM_BITS + 34;

    logic [ELEM_BITS+vln_pkg::TDATA_BITS-1:0] in_ext;
    logic signed [ELEM_BITS-1:0]              in_elem;
    logic signed [ELEM_BITS-1:0]              mem [MAX_LEN];
    logic signed [ELEM_BITS-1:0]              rd_data_reg;
    logic signed [PW-1:0]                     ld_sq;
    logic signed [PW-1:0]                     rd_sq;
    logic [PW-1:0]                            ld_sq_reg;
    logic                                     ld_v_reg;
    logic [SW-1:0]                            sum_reg;
    logic                                     sum_zero;
    logic [W-1:0]                             rem_reg;
    logic [W-1:0]                             part_reg;
    logic [W-1:0]                             step_reg;
    logic [vln_pkg::ROOT_BITS-1:0]            root_reg;
    logic                                     neg_reg;
    logic [W+1:0]                             diff;
    logic                                     take;
    logic [vln_pkg::COMP_BITS-1:0]            root_ext;
    logic [vln_pkg::COMP_BITS-1:0]            comp;
    logic [vln_pkg::COMP_BITS-1:0]            m_tdata_reg;
    logic                                     m_tlast_reg;
    logic                                     m_zero_reg;

    assign in_ext  = {ELEM_BITS'(0), s_tdata};
    assign in_elem = in_ext[ELEM_BITS-1:0];
    assign ld_sq   = in_elem * in_elem;
    assign rd_sq   = rd_data_reg * rd_data_reg;

    // element store
    always_ff @(posedge aclk) begin
        if (cmd.store_we) begin
            mem[store_addr] <= in_elem;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // sum of squares, square registered before accumulation
    always_ff @(posedge aclk) begin
        if (cmd.store_we) begin
            ld_sq_reg <= $unsigned(ld_sq);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ld_v_reg <= 1'b0;
            sum_reg  <= '0;
        end else begin
            ld_v_reg <= cmd.store_we;
            if (cmd.clear_sum) begin
                sum_reg <= '0;
            end else if (ld_v_reg) begin
                sum_reg <= sum_reg + SW'(ld_sq_reg);
            end
        end
    end

    assign sum_zero = (sum_reg == '0);

    // root unit: largest m with m*m*S <= e*e*2^28, one bit per step.
    // rem = e^2*2^28 - m^2*S, part = m*S << (b+1), step = S << 2b
    assign diff = {2'b00, rem_reg} - {2'b00, part_reg} - {2'b00, step_reg};
    assign take = !diff[W+1];

    always_ff @(posedge aclk) begin
        if (cmd.init) begin
            rem_reg  <= W'({$unsigned(rd_sq), {vln_pkg::SCALE_SHIFT{1'b0}}});
            part_reg <= '0;
            step_reg <= W'({sum_reg, {vln_pkg::SCALE_SHIFT{1'b0}}});
            neg_reg  <= rd_data_reg[ELEM_BITS-1];
            root_reg <= '0;
        end else if (cmd.step) begin
            if (take) begin
                rem_reg  <= diff[W-1:0];
                part_reg <= (part_reg >> 1) + step_reg;
            end else begin
                part_reg <= part_reg >> 1;
            end
            step_reg <= step_reg >> 2;
            root_reg <= {root_reg[vln_pkg::ROOT_BITS-2:0], take};
        end
    end

    assign root_ext = {1'b0, root_reg};
    assign comp     = neg_reg ? (vln_pkg::COMP_BITS'(0) - root_ext) : root_ext;

    // output register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata_reg <= sum_zero ? '0 : comp;
            m_tlast_reg <= cmd.out_last;
            m_zero_reg  <= sum_zero;
        end
    end

    assign m_tdata    = m_tdata_reg;
    assign m_tlast    = m_tlast_reg;
    assign m_tuser[0] = m_zero_reg;

endmodule

/* design/vector_l2_normalize_unit.sv */
// Top level of the vector L2 normalisation unit: controller plus datapath.
// Depends on vln_pkg, vln_ctrl, vln_datapath and assert_macros.svh.
//
// Elements stream in one per cycle, a transfer with tlast ending the vector (up to
// MAX_LEN are kept, later ones dropped). The sum of squares settles in a settle state,
// then each stored element is emitted in load order as a Q1.14 component truncated
// toward zero, with tlast on the last one and tuser set for an all-zero vector.
// Each result takes a store read, an init state that squares the element and loads
// the root unit, 15 steps of the shared shift-and-subtract root unit and a load into
// the output register. No input is taken while a vector is being emitted; the next
// vector starts loading while the final result still waits in the output register.
`include "assert_macros.svh"

module vector_l2_normalize_unit #(
    parameter int MAX_LEN   = 64,
    parameter int ELEM_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] element
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] component
    output logic        m_tlast,
    output logic [0:0]  m_tuser    // [0] zero_norm
);

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = $clog2(MAX_LEN + 1);

    vln_pkg::cmd_t   cmd;
    logic [AW-1:0]   store_addr;
    logic [AW-1:0]   rd_addr;

    vln_ctrl #(
        .MAX_LEN (MAX_LEN),
        .AW      (AW),
        .CW      (CW)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tlast    (s_tlast),
        .s_tready   (s_tready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .cmd        (cmd),
        .store_addr (store_addr),
        .rd_addr    (rd_addr)
    );

    vln_datapath #(
        .MAX_LEN   (MAX_LEN),
        .ELEM_BITS (ELEM_BITS),
        .AW        (AW)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .s_tdata    (s_tdata),
        .store_addr (store_addr),
        .rd_addr    (rd_addr),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

    `ASSERT_NEVER(a_no_load_while_iter, aclk, aresetn, s_tready && cmd.step, "input taken during root iteration")
    `ASSERT_NEVER(a_no_store_during_emit, aclk, aresetn, cmd.store_we && cmd.out_load, "store write while emitting")
    `ASSERT_IMPLY(a_zero_norm_value, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata == 16'd0, "zero norm result not zero")
    `ASSERT_IMPLY(a_comp_range, aclk, aresetn, m_tvalid, ($signed(m_tdata) <= 16'sd16384) && ($signed(m_tdata) >= -16'sd16384), "component out of Q1.14 range")

endmodule

/* bench/vector_l2_normalize_unit_tb.sv */
// Self-checking bench for vector_l2_normalize_unit: streams vectors with random gaps and
// stalls, predicts every normalised component and compares it on the result stream.
// Depends on vln_pkg and the vector_l2_normalize_unit RTL.
module vector_l2_normalize_unit_tb;

    localparam int VEC_DEPTH   = 64;
    localparam int CYCLE_LIMIT = 400000;
    localparam int REPORT_MAX  = 10;
    localparam int ITEM_TARGET = 230;

    typedef struct packed {
        logic [15:0] element;
        logic        last;
    } elem_xfer_t;

    typedef struct packed {
        logic [vln_pkg::COMP_BITS-1:0] component;
        logic                          final_res;
        logic                          zero_norm;
    } norm_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic [0:0]  m_tuser;

    vector_l2_normalize_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [15:0] element
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [15:0] component
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)    // [0] zero_norm
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    elem_xfer_t   elem_queue[$];
    norm_result_t norm_expected[$];

    logic signed [15:0] vec_store [VEC_DEPTH];
    int unsigned        vec_fill = 0;
    logic [36:0]        vec_sq_sum = '0;

    int tx_gap = 0;
    int tx_calm = 0;
    int rx_hold = 0;
    int rx_calm = 0;
    int cycle_count = 0;
    int mismatch_count = 0;
    int vectors_done = 0;
    int zero_vectors = 0;
    int overflow_vectors = 0;
    int components_checked = 0;
    int stored_items = 0;

    function automatic int draw_wait(inout int calm);
        int w;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            calm = $urandom_range(8, 40);
            return 0;
        end
        case ($urandom_range(0, 3))
            0: begin
                w = 0;
            end
            1: begin
                w = $urandom_range(0, 2);
            end
            default: begin
                w = $urandom_range(0, 18);
            end
        endcase
        return w;
    endfunction

    // Largest m with m*m*sum <= mag*mag*2^28, resolved from the top bit down.
    function automatic logic [15:0] unit_magnitude(logic [15:0] mag, logic [36:0] sum);
        logic [127:0] rhs;
        logic [127:0] lhs;
        logic [15:0]  m;
        logic [15:0]  t;
        int           b;
        rhs = ({112'd0, mag} * mag) << vln_pkg::SCALE_SHIFT;
        m = '0;
        for (b = vln_pkg::ROOT_BITS - 1; b >= 0; b--) begin
            t = m | (16'd1 << b);
            lhs = {112'd0, t} * t * sum;
            if (lhs <= rhs) begin
                m = t;
            end
        end
        return m;
    endfunction

    function automatic void absorb_element(logic [15:0] raw, logic last);
        logic [15:0]  mag;
        logic [15:0]  m;
        norm_result_t r;
        int unsigned  i;
        if (vec_fill < VEC_DEPTH) begin
            mag = raw[15] ? (~raw + 16'd1) : raw;
            vec_store[vec_fill] = raw;
            vec_fill++;
            vec_sq_sum = vec_sq_sum + {21'd0, mag} * mag;
        end else if (last) begin
            overflow_vectors++;
        end
        if (!last) begin
            return;
        end
        for (i = 0; i < vec_fill; i++) begin
            mag = vec_store[i][15] ? (~vec_store[i] + 16'd1) : vec_store[i];
            m = (vec_sq_sum == 0) ? 16'd0 : unit_magnitude(mag, vec_sq_sum);
            r.component = vec_store[i][15] ? (16'd0 - m) : m;
            r.final_res = (i + 1 == vec_fill);
            r.zero_norm = (vec_sq_sum == 0);
            norm_expected = {norm_expected, r};
        end
        vectors_done++;
        if (vec_sq_sum == 0) begin
            zero_vectors++;
        end
        vec_fill = 0;
        vec_sq_sum = '0;
    endfunction

    // Input side
    always @(posedge aclk) begin
        elem_xfer_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_gap <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                absorb_element(s_tdata, s_tlast);
            end
            if (!s_tvalid || s_tready) begin
                if (tx_gap > 0) begin
                    tx_gap <= tx_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (elem_queue.size() != 0) begin
                    nxt = elem_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= nxt.element;
                    s_tlast <= nxt.last;
                    tx_gap <= draw_wait(tx_calm);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result side
    always @(posedge aclk) begin
        norm_result_t want;
        int           w;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_hold <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                components_checked++;
                if (norm_expected.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX) begin
                        $display("unexpected transfer: component %0d tlast %0b tuser %0b",
                                 $signed(m_tdata), m_tlast, m_tuser[0]);
                    end
                end else begin
                    want = norm_expected.pop_front();
                    if (m_tdata !== want.component || m_tlast !== want.final_res
                            || m_tuser[0] !== want.zero_norm) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX) begin
                            $display("mismatch: component %0d/%0d tlast %0b/%0b tuser %0b/%0b",
                                     $signed(m_tdata), $signed(want.component), m_tlast,
                                     want.final_res, m_tuser[0], want.zero_norm);
                        end
                    end
                end
                w = draw_wait(rx_calm);
                if (w > 0) begin
                    m_tready <= 1'b0;
                    rx_hold <= w;
                end
            end else if (rx_hold > 0) begin
                rx_hold <= rx_hold - 1;
                if (rx_hold == 1) begin
                    m_tready <= 1'b1;
                end
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("vector_l2_normalize_unit_tb: errors");
            $finish;
        end
    end

    task automatic queue_vector(logic [15:0] elems[$]);
        int         k;
        elem_xfer_t x;
        for (k = 0; k < elems.size(); k++) begin
            x.element = elems[k];
            x.last = (k == elems.size() - 1);
            elem_queue = {elem_queue, x};
        end
    endtask

    function automatic logic [15:0] draw_element(int style);
        logic [15:0] picks[5];
        picks = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001};
        case (style)
            0, 1: begin
                return 16'($urandom_range(0, 65535));
            end
            2: begin
                return 16'(int'($urandom_range(0, 40)) - 20);
            end
            3: begin
                return picks[$urandom_range(0, 4)];
            end
            4: begin
                return 16'h0000;
            end
            default: begin
                return draw_element($urandom_range(0, 3));
            end
        endcase
    endfunction

    initial begin
        logic [15:0] vec[$];
        int len, style, k;

        // directed: zero vectors, extremes, exact ratios
        queue_vector('{16'h0000});
        queue_vector('{16'h7fff});
        queue_vector('{16'h8000});
        queue_vector('{16'h0000, 16'h0000, 16'h0000});
        queue_vector('{16'h8000, 16'h7fff, 16'h0000, 16'h0001, 16'hffff});
        queue_vector('{16'd3, 16'd4});
        queue_vector('{16'h0000, 16'h0000, 16'd5});
        queue_vector('{16'h8000, 16'h8000, 16'h8000, 16'h8000});
        stored_items = 20;

        while (stored_items < ITEM_TARGET) begin
            len = ($urandom_range(0, 11) == 0) ? $urandom_range(60, 72)
                                               : $urandom_range(1, 10);
            if (len > ITEM_TARGET - stored_items) begin
                len = ITEM_TARGET - stored_items;
            end
            style = $urandom_range(0, 5);
            if (style == 4 && $urandom_range(0, 1) == 0) begin
                style = 0;
            end
            vec = {};
            for (k = 0; k < len; k++) begin
                vec = {vec, draw_element(style)};
            end
            queue_vector(vec);
            stored_items += (len > VEC_DEPTH) ? VEC_DEPTH : len;
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (elem_queue.size() != 0 || s_tvalid) begin
            @(posedge aclk);
        end
        while (norm_expected.size() != 0) begin
            @(posedge aclk);
        end
        repeat (40) @(posedge aclk);

        $display("covered %0d vectors (%0d all-zero, %0d over-length), %0d components checked",
                 vectors_done, zero_vectors, overflow_vectors, components_checked);
        $display("mismatches: %0d", mismatch_count);
        if (mismatch_count == 0) begin
            $display("vector_l2_normalize_unit_tb: clean");
        end else begin
            $display("vector_l2_normalize_unit_tb: errors");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+design
design/vln_pkg.sv
design/vln_ctrl.sv
design/vln_datapath.sv
design/vector_l2_normalize_unit.sv
bench/vector_l2_normalize_unit_tb.sv
